// File: hdl/gbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_pkg
// Types, S-box constants and key schedule for the 64-bit Feistel block cipher.
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int unsigned HalfW   = 32;
  localparam int unsigned KeyN    = 8;
  localparam int unsigned Rounds  = 32;
  localparam int unsigned Shift   = 11;
  localparam int unsigned CfgIdxW = 4;

  typedef enum logic {
    ACT_ENCRYPT = 1'b0,
    ACT_DECRYPT = 1'b1
  } action_e;

  typedef struct packed {
    action_e           action;
    logic [HalfW-1:0]  block_high;
    logic [HalfW-1:0]  block_low;
  } in_t;

  typedef struct packed {
    logic [HalfW-1:0]  result_high;
    logic [HalfW-1:0]  result_low;
  } out_t;

  // Per-stage pipeline state.
  typedef struct packed {
    action_e           action;
    logic [HalfW-1:0]  passive;
    logic [HalfW-1:0]  active;
  } stage_t;

  // Row n holds S-box n, entry i in bits [4i+3:4i].
  localparam logic [63:0] SBOX [KeyN] = '{
    64'h35F7C1B6E08D29A4,
    64'h95701832AFD6C4BE,
    64'hB9067CFE243AD185,
    64'h352BC64EF9801AD7,
    64'h2B30E9A48DF517C6,
    64'hEFC95863D1270AB4,
    64'hC2867EA095F314BD,
    64'hC8B6E3294A750DF1
  };

  function automatic logic [3:0] sbox_lookup(input int unsigned row, input logic [3:0] nib);
    logic [63:0] r;
    r = SBOX[row];
    return r[{nib, 2'b00} +: 4];
  endfunction

  // Key word used at schedule step: 0..7 three times, then 7..0.
  function automatic logic [2:0] sched_index(input int unsigned step);
    logic [4:0] s;
    s = step[4:0];
    if (s < 5'd24) begin
      return s[2:0];
    end else begin
      return ~s[2:0];
    end
  endfunction

endpackage

// File: hdl/gbc_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_round
// One cipher round: key add mod 2^32, S-box layer, rotate left, XOR.
// ----------------------------------------------------------------------------
module gbc_round (
  input  logic [gbc_pkg::HalfW-1:0] active_i,
  input  logic [gbc_pkg::HalfW-1:0] passive_i,
  input  logic [gbc_pkg::HalfW-1:0] key_i,
  output logic [gbc_pkg::HalfW-1:0] fresh_o
);

  logic [gbc_pkg::HalfW-1:0] sum;
  logic [gbc_pkg::HalfW-1:0] sub;
  logic [gbc_pkg::HalfW-1:0] rot;

  assign sum = active_i + key_i;

  // S1 sits on the most significant nibble.
  always_comb begin
    for (int unsigned n = 0; n < gbc_pkg::KeyN; n++) begin
      sub[gbc_pkg::HalfW-4-4*n +: 4] = gbc_pkg::sbox_lookup(n, sum[gbc_pkg::HalfW-4-4*n +: 4]);
    end
  end

  assign rot     = {sub[gbc_pkg::HalfW-gbc_pkg::Shift-1:0],
                    sub[gbc_pkg::HalfW-1:gbc_pkg::HalfW-gbc_pkg::Shift]};
  assign fresh_o = passive_i ^ rot;

endmodule

// File: hdl/gbc_top_stub_placeholder_never_used.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_key_regs
// Key word register file, written through the configuration port.
// ----------------------------------------------------------------------------
module gbc_key_regs (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         cfg_we_i,
  input  logic [gbc_pkg::CfgIdxW-1:0]                  cfg_idx_i,
  input  logic [gbc_pkg::HalfW-1:0]                    cfg_data_i,
  output logic [gbc_pkg::KeyN-1:0][gbc_pkg::HalfW-1:0] key_o
);

  logic [gbc_pkg::KeyN-1:0][gbc_pkg::HalfW-1:0] key_q;

  // Indexes 8 and above are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i && !cfg_idx_i[gbc_pkg::CfgIdxW-1]) begin
      key_q[cfg_idx_i[2:0]] <= cfg_data_i;
    end
  end

  assign key_o = key_q;

endmodule

// File: hdl/gost_block_cipher_64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gost_block_cipher_64
// 64-bit block cipher, 32 Feistel rounds, one round per pipeline stage.
//
// Input channel: in_valid_i / in_stall_o with in_data_i (action, block_high,
// block_low). Output channel: out_valid_o / out_stall_i with out_data_o
// (result_high, result_low). A transfer happens on a rising edge with valid
// high and stall low.
// Key words 0..7 are written through cfg_we_i / cfg_idx_i / cfg_data_i; indexes
// 8 and above are ignored. The user must write them only while the pipeline is
// empty; the block itself does not enforce this. There is one register per
// round, so every block passes through all 32 round stages to the output.
// Throughput: one block per cycle while out_stall_i is low (32-stage pipeline).
// Each stage has its own valid bit and loads when empty or when the stage
// after it moves, so bubbles are squeezed out while the receiver stalls.
// in_stall_o rises only when all 32 stages hold data and the output is stalled.
// Reset clears all valid bits and the key words to zero.
// ----------------------------------------------------------------------------
module gost_block_cipher_64 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gbc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gbc_pkg::HalfW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  gbc_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output gbc_pkg::out_t                 out_data_o
);

  localparam int unsigned N = gbc_pkg::Rounds;

  logic [gbc_pkg::KeyN-1:0][gbc_pkg::HalfW-1:0] key_words;
  logic [N-1:0]              vld_q;
  gbc_pkg::stage_t           stg_q [N];
  logic [N:0]                rdy;

  gbc_key_regs u_key_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .key_o      (key_words)
  );

  assign rdy[N] = !out_stall_i;

  for (genvar r = 0; r < N; r++) begin : g_stage
    localparam logic [2:0] KEnc = gbc_pkg::sched_index(r);
    localparam logic [2:0] KDec = gbc_pkg::sched_index(N - 1 - r);

    gbc_pkg::stage_t           src;
    logic                      src_vld;
    logic [gbc_pkg::HalfW-1:0] key;
    logic [gbc_pkg::HalfW-1:0] fresh;
    gbc_pkg::stage_t           stg_d;

    if (r == 0) begin : g_in
      assign src_vld = in_valid_i;
      assign src     = '{action:  in_data_i.action,
                         passive: in_data_i.block_high,
                         active:  in_data_i.block_low};
    end else begin : g_mid
      assign src_vld = vld_q[r-1];
      assign src     = stg_q[r-1];
    end

    assign rdy[r] = !vld_q[r] || rdy[r+1];
    assign key    = (src.action == gbc_pkg::ACT_DECRYPT) ? key_words[KDec] : key_words[KEnc];

    gbc_round u_round (
      .active_i  (src.active),
      .passive_i (src.passive),
      .key_i     (key),
      .fresh_o   (fresh)
    );

    assign stg_d = '{action: src.action, passive: src.active, active: fresh};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[r] <= 1'b0;
      end else if (rdy[r]) begin
        vld_q[r] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[r] && src_vld) begin
        stg_q[r] <= stg_d;
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[N-1];
  assign out_data_o  = '{result_high: stg_q[N-1].active, result_low: stg_q[N-1].passive};

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&vld_q) && out_stall_i))
    else $error("input stalled while pipeline has room");

  a_stage0_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && rdy[1]) |=> vld_q[1])
    else $error("item lost between first and second stage");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[N-1] && out_stall_i) |=> (vld_q[N-1] && $stable(stg_q[N-1])))
    else $error("last stage changed while output stalled");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted item missing from first stage");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gost_block_cipher_64.
//
// Key words are loaded while the pipeline is empty. Each phase then streams a
// batch of blocks through the cipher. A clocked driver feeds the input from a
// queue of pending blocks. A clocked monitor predicts each accepted block from
// its own copy of the key and compares every result transfer, field by field,
// against the oldest prediction. Both sides insert random bubbles and stalls,
// except in one phase that runs at full rate.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned LatencyCyc = 40;
  localparam int unsigned RandPhases = 6;
  localparam int unsigned RandItems  = 250;
  localparam int unsigned IdxW       = gbc_pkg::CfgIdxW;

  localparam int SBOX_ROWS [8][16] = '{
    '{ 4, 10,  9,  2, 13,  8,  0, 14,  6, 11,  1, 12,  7, 15,  5,  3},
    '{14, 11,  4, 12,  6, 13, 15, 10,  2,  3,  8,  1,  0,  7,  5,  9},
    '{ 5,  8,  1, 13, 10,  3,  4,  2, 14, 15, 12,  7,  6,  0,  9, 11},
    '{ 7, 13, 10,  1,  0,  8,  9, 15, 14,  4,  6, 12, 11,  2,  5,  3},
    '{ 6, 12,  7,  1,  5, 15, 13,  8,  4, 10,  9, 14,  0,  3, 11,  2},
    '{ 4, 11, 10,  0,  7,  2,  1, 13,  3,  6,  8,  5,  9, 12, 15, 14},
    '{13, 11,  4,  1,  3, 15,  5,  9,  0, 10, 14,  7,  6,  8,  2, 12},
    '{ 1, 15, 13,  0,  5,  7, 10,  4,  9,  2,  3, 14,  6, 11,  8, 12}
  };

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [IdxW-1:0]           cfg_idx;
  logic [gbc_pkg::HalfW-1:0] cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  gbc_pkg::in_t              in_data;
  logic                      out_valid;
  logic                      out_stall;
  gbc_pkg::out_t             out_data;

  logic [gbc_pkg::HalfW-1:0] key_model [gbc_pkg::KeyN];
  logic [gbc_pkg::HalfW-1:0] key_next  [gbc_pkg::KeyN];
  gbc_pkg::in_t              block_pend_q [$];
  gbc_pkg::out_t             cipher_exp_q [$];
  bit                        in_fire;
  bit                        calm;
  int unsigned               n_blocks;
  int unsigned               n_results;
  int unsigned               n_keysets;
  int unsigned               n_err;

  gost_block_cipher_64 dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #1 clk = ~clk;

  function automatic logic [gbc_pkg::HalfW-1:0] round_mix(
      input logic [gbc_pkg::HalfW-1:0] half,
      input logic [gbc_pkg::HalfW-1:0] k);
    logic [gbc_pkg::HalfW-1:0] sum;
    logic [gbc_pkg::HalfW-1:0] sub;
    int                        n;
    sum = half + k;
    sub = '0;
    for (n = 0; n < 8; n++) begin
      sub[28-4*n +: 4] = 4'(SBOX_ROWS[n][sum[28-4*n +: 4]]);
    end
    return {sub[20:0], sub[31:21]};
  endfunction

  function automatic gbc_pkg::out_t gost_cipher(input gbc_pkg::in_t blk);
    logic [gbc_pkg::HalfW-1:0] passive;
    logic [gbc_pkg::HalfW-1:0] active;
    logic [gbc_pkg::HalfW-1:0] fresh;
    int                        r;
    int                        step;
    int                        ki;
    gbc_pkg::out_t             res;
    passive = blk.block_high;
    active  = blk.block_low;
    for (r = 0; r < 32; r++) begin
      step    = (blk.action == gbc_pkg::ACT_DECRYPT) ? 31 - r : r;
      ki      = (step < 24) ? step % 8 : 31 - step;
      fresh   = passive ^ round_mix(active, key_model[ki]);
      passive = active;
      active  = fresh;
    end
    res.result_high = active;
    res.result_low  = passive;
    return res;
  endfunction

  function automatic logic [gbc_pkg::HalfW-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  function automatic gbc_pkg::in_t mk_block(input gbc_pkg::action_e act,
                                            input logic [gbc_pkg::HalfW-1:0] hi,
                                            input logic [gbc_pkg::HalfW-1:0] lo);
    gbc_pkg::in_t b;
    b.action     = act;
    b.block_high = hi;
    b.block_low  = lo;
    return b;
  endfunction

  function automatic void queue_block(input gbc_pkg::in_t b);
    block_pend_q = {block_pend_q, b};
  endfunction

  // Input side: predict on transfer, keep the key copy in step with writes.
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) begin
      cipher_exp_q = {cipher_exp_q, gost_cipher(in_data)};
      n_blocks++;
    end
    if (rst_n && cfg_we && cfg_idx < gbc_pkg::KeyN) begin
      key_model[cfg_idx] = cfg_data;
    end
  end

  // Output side: compare each result transfer against the oldest prediction.
  always @(posedge clk) begin
    gbc_pkg::out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (cipher_exp_q.size() == 0) begin
        $display("%0t: unexpected result %h_%h", $time, out_data.result_high,
                 out_data.result_low);
        n_err++;
      end else begin
        exp_r = cipher_exp_q.pop_front();
        if (out_data.result_high !== exp_r.result_high) begin
          $display("%0t: result_high mismatch exp %h got %h", $time,
                   exp_r.result_high, out_data.result_high);
          n_err++;
        end
        if (out_data.result_low !== exp_r.result_low) begin
          $display("%0t: result_low mismatch exp %h got %h", $time,
                   exp_r.result_low, out_data.result_low);
          n_err++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (block_pend_q.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
          in_data  <= block_pend_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 18);
    end
  end

  task automatic write_keys();
    int i;
    for (i = 0; i < gbc_pkg::KeyN; i++) begin
      @(negedge clk);
      cfg_we   <= 1'b1;
      cfg_idx  <= IdxW'(i);
      cfg_data <= key_next[i];
    end
    // index past the key file, must be ignored
    @(negedge clk);
    cfg_idx  <= IdxW'($urandom_range(gbc_pkg::KeyN, 2**IdxW - 1));
    cfg_data <= $urandom;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_keysets++;
  endtask

  task automatic wait_drained();
    while (block_pend_q.size() != 0 || in_valid || cipher_exp_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (LatencyCyc) @(posedge clk);
  endtask

  initial begin
    int            p;
    int            i;
    gbc_pkg::in_t  b;
    gbc_pkg::out_t e;
    clk       = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    calm      = 1'b0;
    n_blocks  = 0;
    n_results = 0;
    n_keysets = 1;
    n_err     = 0;
    for (i = 0; i < gbc_pkg::KeyN; i++) key_model[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // all-zero key out of reset
    queue_block(mk_block(gbc_pkg::ACT_ENCRYPT, '0, '0));
    queue_block(mk_block(gbc_pkg::ACT_DECRYPT, '0, '0));
    queue_block(mk_block(gbc_pkg::ACT_ENCRYPT, '1, '1));
    queue_block(mk_block(gbc_pkg::ACT_DECRYPT, '1, '1));
    queue_block(mk_block(gbc_pkg::ACT_ENCRYPT, 32'hAAAAAAAA, 32'h55555555));
    queue_block(mk_block(gbc_pkg::ACT_DECRYPT, 32'h55555555, 32'hAAAAAAAA));
    queue_block(mk_block(gbc_pkg::ACT_ENCRYPT, 32'h80000000, 32'h00000001));
    queue_block(mk_block(gbc_pkg::ACT_ENCRYPT, '0, 32'hF0000000));
    wait_drained();

    // all-ones key: the key add wraps on every nonzero half
    for (i = 0; i < gbc_pkg::KeyN; i++) key_next[i] = '1;
    write_keys();
    queue_block(mk_block(gbc_pkg::ACT_ENCRYPT, '0, '0));
    queue_block(mk_block(gbc_pkg::ACT_ENCRYPT, '0, '1));
    queue_block(mk_block(gbc_pkg::ACT_DECRYPT, '1, '0));
    queue_block(mk_block(gbc_pkg::ACT_DECRYPT, '1, '1));
    queue_block(mk_block(gbc_pkg::ACT_ENCRYPT, 32'h00000001, 32'h00000001));
    queue_block(mk_block(gbc_pkg::ACT_DECRYPT, 32'h0F0F0F0F, 32'hF0F0F0F0));
    wait_drained();

    // random key words; encrypt then decrypt the predicted ciphertext
    for (i = 0; i < gbc_pkg::KeyN; i++) key_next[i] = $urandom;
    write_keys();
    for (i = 0; i < 5; i++) begin
      b = mk_block(gbc_pkg::ACT_ENCRYPT, $urandom, $urandom);
      e = gost_cipher(b);
      queue_block(b);
      queue_block(mk_block(gbc_pkg::ACT_DECRYPT, e.result_high, e.result_low));
    end
    wait_drained();

    for (p = 0; p < RandPhases; p++) begin
      for (i = 0; i < gbc_pkg::KeyN; i++) key_next[i] = rand_word();
      write_keys();
      calm = (p == 2);
      for (i = 0; i < RandItems; i++) begin
        b = mk_block(gbc_pkg::action_e'($urandom_range(0, 1)), rand_word(), rand_word());
        queue_block(b);
        if ($urandom_range(0, 9) == 0) begin
          e = gost_cipher(b);
          queue_block(mk_block($urandom_range(0, 1) ? gbc_pkg::ACT_DECRYPT
                                                    : gbc_pkg::ACT_ENCRYPT,
                               e.result_high, e.result_low));
        end
      end
      wait_drained();
      calm = 1'b0;
    end

    if (cipher_exp_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, cipher_exp_q.size());
      n_err++;
    end
    $display("Covered %0d blocks and %0d results over %0d key settings, %0d errors",
             n_blocks, n_results, n_keysets, n_err);
    if (n_err == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// File: gost_block_cipher_64.f
hdl/gbc_pkg.sv
hdl/gbc_round.sv
hdl/gbc_top_stub_placeholder_never_used.sv
hdl/gost_block_cipher_64.sv
tb/tb.sv
